[rtl/xcr_pkg.sv]
// shared types, constants and protocol codes of the xmodem checksum receiver
`default_nettype none
package xcr_pkg;

  // default geometry
  localparam int BUFFER_BYTES_DEF = 65536;
  localparam int BLOCK_BYTES_DEF  = 128;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int INTERVAL_W = 21;
  localparam int OFFSET_W   = 16;
  localparam int SIZE_W     = 17;
  localparam int STATUS_W   = 3;

  localparam logic [INTERVAL_W-1:0] NAK_INTERVAL_RESET = INTERVAL_W'(2000000);

  // line control characters
  localparam logic [BYTE_W-1:0] C_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] C_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] C_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] C_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] C_CAN = 8'h18;
  localparam logic [BYTE_W-1:0] C_ALL_ONES = 8'hff;

  // input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_BLKNUM = 3'd1,
    PH_COMPL  = 3'd2,
    PH_DATA   = 3'd3,
    PH_SUM    = 3'd4
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING   = 3'd0,
    ST_FINISHED  = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_PROTOCOL  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // one result item
  typedef struct packed {
    logic                send_valid;
    logic [BYTE_W-1:0]   send_byte;
    logic                write_valid;
    logic [BYTE_W-1:0]   write_byte;
    logic [OFFSET_W-1:0] write_offset;
    logic                block_accepted;
    status_t             status;
    logic [SIZE_W-1:0]   received_size;
  } result_t;

endpackage
`default_nettype wire

[rtl/xmodem_checksum_receiver.sv]
// top level of the xmodem checksum receiver
// XMODEM receive side with 8-bit checksum and BLOCK_BYTES-byte blocks. Each input transfer
// is a line byte (mode 0) or a time tick (mode 1) and yields exactly one result transfer:
// an optional ACK/NAK reply, an optional data byte with its buffer offset, a block-accepted
// flag, a status code and the accepted size. An item passes an input register, combinational
// protocol logic and a result register, so one item is taken every clock cycle while the
// output is not stalled. An item is registered first in the input register and then, with
// its result, in the result register, from which the outputs are driven. A stalled result
// holds the input register, and in_stall follows out_stall when both registers are full.
// The user must write nak_interval through cfg_write_enable/cfg_write_data only while no
// transfer is in flight; the block itself does not enforce this.
`default_nettype none
module xmodem_checksum_receiver #(
  parameter int BUFFER_BYTES = xcr_pkg::BUFFER_BYTES_DEF,
  parameter int BLOCK_BYTES  = xcr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_enable,
  input  wire logic [xcr_pkg::INTERVAL_W-1:0] cfg_write_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic [xcr_pkg::BYTE_W-1:0]     rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                send_valid,
  output logic [xcr_pkg::BYTE_W-1:0]          send_byte,
  output logic                                write_valid,
  output logic [xcr_pkg::BYTE_W-1:0]          write_byte,
  output logic [xcr_pkg::OFFSET_W-1:0]        write_offset,
  output logic                                block_accepted,
  output logic [xcr_pkg::STATUS_W-1:0]        status,
  output logic [xcr_pkg::SIZE_W-1:0]          received_size
);

  logic [xcr_pkg::INTERVAL_W-1:0] nak_interval;
  logic                           take;
  logic                           held;
  logic                           held_mode;
  logic [xcr_pkg::BYTE_W-1:0]     held_byte;
  xcr_pkg::result_t               core_result;
  xcr_pkg::result_t               result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      nak_interval <= xcr_pkg::NAK_INTERVAL_RESET;
    end else if (cfg_write_enable) begin
      nak_interval <= cfg_write_data;
    end
  end

  xcr_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .rx_byte   (rx_byte),
    .take      (take),
    .held      (held),
    .held_mode (held_mode),
    .held_byte (held_byte)
  );

  xcr_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (held && take),
    .mode         (held_mode),
    .rx_byte      (held_byte),
    .nak_interval (nak_interval),
    .result       (core_result)
  );

  xcr_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (held),
    .load_result (core_result),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  // result fields to ports
  assign send_valid     = result.send_valid;
  assign send_byte      = result.send_byte;
  assign write_valid    = result.write_valid;
  assign write_byte     = result.write_byte;
  assign write_offset   = result.write_offset;
  assign block_accepted = result.block_accepted;
  assign status         = result.status;
  assign received_size  = result.received_size;

endmodule
`default_nettype wire

[rtl/xcr_in_stage.sv]
// input register that holds one line byte or tick until the core takes it
`default_nettype none
module xcr_in_stage (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     mode,
  input  wire logic [xcr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                     take,
  output logic                          held,
  output logic                          held_mode,
  output logic [xcr_pkg::BYTE_W-1:0]    held_byte
);

  // stall only while a held item cannot move on
  assign in_stall = held && !take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_mode <= mode;
      held_byte <= rx_byte;
    end
  end

endmodule
`default_nettype wire

[rtl/xcr_core.sv]
// protocol state and per-item result logic of the receiver
`default_nettype none
module xcr_core #(
  parameter int BUFFER_BYTES = xcr_pkg::BUFFER_BYTES_DEF,
  parameter int BLOCK_BYTES  = xcr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire logic                          mode,
  input  wire logic [xcr_pkg::BYTE_W-1:0]    rx_byte,
  input  wire logic [xcr_pkg::INTERVAL_W-1:0] nak_interval,
  output xcr_pkg::result_t                   result
);

  localparam int CNT_MAX = (BUFFER_BYTES > BLOCK_BYTES) ? BUFFER_BYTES : BLOCK_BYTES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int CMP_W   = CNT_W + 1;
  localparam int IDX_W   = $clog2(BLOCK_BYTES);
  localparam int OFS_W   = (CNT_W > xcr_pkg::OFFSET_W) ? CNT_W : xcr_pkg::OFFSET_W;
  localparam int EXT_W   = (CNT_W > xcr_pkg::SIZE_W) ? CNT_W : xcr_pkg::SIZE_W;

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [CNT_W-1:0] BLOCK_CNT  = CNT_W'(BLOCK_BYTES);
  localparam logic [CMP_W-1:0] BLOCK_CMP  = CMP_W'(BLOCK_BYTES);
  localparam logic [CMP_W-1:0] BUFFER_CMP = CMP_W'(BUFFER_BYTES);

  xcr_pkg::phase_t                    phase, phase_next;
  logic                               transfer_started, transfer_started_next;
  logic [xcr_pkg::BYTE_W-1:0]         expected_block, expected_block_next;
  logic [IDX_W-1:0]                   byte_index, byte_index_next;
  logic [xcr_pkg::BYTE_W-1:0]         running_sum, running_sum_next;
  logic [CNT_W-1:0]                   byte_count, byte_count_next;
  logic [xcr_pkg::INTERVAL_W-1:0]     nak_timer, nak_timer_next;

  logic                               finish;
  logic                               no_room;
  logic [xcr_pkg::INTERVAL_W-1:0]     timer_inc;
  logic [OFS_W-1:0]                   offset_sum;
  logic [EXT_W-1:0]                   size_ext;

  // side computations
  assign timer_inc  = nak_timer + xcr_pkg::INTERVAL_W'(1);
  assign no_room    = (CMP_W'(byte_count) + BLOCK_CMP) > BUFFER_CMP;
  assign offset_sum = OFS_W'(byte_count) + OFS_W'(byte_index);

  // next state and result
  always_comb begin
    phase_next            = phase;
    transfer_started_next = transfer_started;
    expected_block_next   = expected_block;
    byte_index_next       = byte_index;
    running_sum_next      = running_sum;
    byte_count_next       = byte_count;
    nak_timer_next        = nak_timer;
    finish                = 1'b0;
    result                = '0;
    result.status         = xcr_pkg::ST_RUNNING;

    if (mode == xcr_pkg::MODE_TICK) begin
      // ticks only matter while waiting for the first block
      if (phase == xcr_pkg::PH_HEADER && !transfer_started) begin
        nak_timer_next = timer_inc;
        if (timer_inc >= nak_interval) begin
          nak_timer_next    = '0;
          result.send_valid = 1'b1;
          result.send_byte  = xcr_pkg::C_NAK;
        end
      end
    end else begin
      case (phase)
        xcr_pkg::PH_HEADER: begin
          if (!transfer_started) begin
            nak_timer_next = '0;
          end
          if (rx_byte == xcr_pkg::C_EOT) begin
            result.send_valid = 1'b1;
            result.send_byte  = xcr_pkg::C_ACK;
            result.status     = xcr_pkg::ST_FINISHED;
            finish            = 1'b1;
          end else if (rx_byte == xcr_pkg::C_CAN) begin
            result.status = xcr_pkg::ST_CANCELLED;
            finish        = 1'b1;
          end else if (rx_byte == xcr_pkg::C_SOH) begin
            transfer_started_next = 1'b1;
            if (no_room) begin
              result.status = xcr_pkg::ST_FULL;
              finish        = 1'b1;
            end else begin
              phase_next = xcr_pkg::PH_BLKNUM;
            end
          end else if (transfer_started) begin
            result.status = xcr_pkg::ST_PROTOCOL;
            finish        = 1'b1;
          end
        end
        xcr_pkg::PH_BLKNUM: begin
          if (rx_byte != expected_block) begin
            result.send_valid = 1'b1;
            result.send_byte  = xcr_pkg::C_NAK;
            phase_next        = xcr_pkg::PH_HEADER;
          end else begin
            phase_next = xcr_pkg::PH_COMPL;
          end
        end
        xcr_pkg::PH_COMPL: begin
          if ((expected_block ^ rx_byte) != xcr_pkg::C_ALL_ONES) begin
            result.send_valid = 1'b1;
            result.send_byte  = xcr_pkg::C_NAK;
            phase_next        = xcr_pkg::PH_HEADER;
          end else begin
            phase_next       = xcr_pkg::PH_DATA;
            byte_index_next  = '0;
            running_sum_next = '0;
          end
        end
        xcr_pkg::PH_DATA: begin
          result.write_valid  = 1'b1;
          result.write_byte   = rx_byte;
          result.write_offset = offset_sum[xcr_pkg::OFFSET_W-1:0];
          running_sum_next    = running_sum + rx_byte;
          if (byte_index == IDX_LAST) begin
            byte_index_next = '0;
            phase_next      = xcr_pkg::PH_SUM;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
        xcr_pkg::PH_SUM: begin
          result.send_valid = 1'b1;
          if (running_sum == rx_byte) begin
            result.send_byte      = xcr_pkg::C_ACK;
            result.block_accepted = 1'b1;
            expected_block_next   = expected_block + xcr_pkg::BYTE_W'(1);
            byte_count_next       = byte_count + BLOCK_CNT;
          end else begin
            result.send_byte = xcr_pkg::C_NAK;
          end
          running_sum_next = '0;
          byte_index_next  = '0;
          phase_next       = xcr_pkg::PH_HEADER;
        end
        default: begin
          phase_next = xcr_pkg::PH_HEADER;
        end
      endcase
    end

    // size is reported before a restart clears it
    size_ext             = EXT_W'(byte_count_next);
    result.received_size = size_ext[xcr_pkg::SIZE_W-1:0];

    // restart after finish or abort
    if (finish) begin
      phase_next            = xcr_pkg::PH_HEADER;
      transfer_started_next = 1'b0;
      expected_block_next   = xcr_pkg::BYTE_W'(1);
      byte_index_next       = '0;
      running_sum_next      = '0;
      byte_count_next       = '0;
      nak_timer_next        = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= xcr_pkg::PH_HEADER;
      transfer_started <= 1'b0;
      expected_block   <= xcr_pkg::BYTE_W'(1);
      byte_index       <= '0;
      running_sum      <= '0;
      byte_count       <= '0;
      nak_timer        <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      transfer_started <= transfer_started_next;
      expected_block   <= expected_block_next;
      byte_index       <= byte_index_next;
      running_sum      <= running_sum_next;
      byte_count       <= byte_count_next;
      nak_timer        <= nak_timer_next;
    end
  end

endmodule
`default_nettype wire

[rtl/xcr_out_stage.sv]
// result register that holds one result until the consumer takes it
`default_nettype none
module xcr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load_valid,
  input  wire xcr_pkg::result_t load_result,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output xcr_pkg::result_t      result
);

  // the register can load when empty or when its content leaves now
  assign take = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      result <= load_result;
    end
  end

endmodule
`default_nettype wire
